// ----- design/array_linked_list_table_top_defines.svh -----
// Assertion macros shared by the table modules.
`ifndef ARRAY_LINKED_LIST_TABLE_TOP_DEFINES_SVH
`define ARRAY_LINKED_LIST_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ALLT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("table check failed");
// Check that a condition never holds outside reset.
`define ALLT_ASSERT_NEVER(name, clk, rst, cond) \
  `ALLT_ASSERT(name, clk, rst, !(cond))
`else
`define ALLT_ASSERT(name, clk, rst, prop)
`define ALLT_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

// ----- design/allt_pkg.sv -----
package allt_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = 4;
  localparam int PTR_W     = 5;
  localparam int KEY_W     = 20;
  localparam int COUNT_W   = 5;

  localparam logic [PTR_W-1:0]   NULL_PTR  = PTR_W'(SLOTS);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(SLOTS);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef struct packed {
    command_t          command;
    logic [KEY_W-1:0]  key;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;
    logic [PTR_W-1:0]    head_slot;
    logic [PTR_W-1:0]    tail_slot;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_WRITE,
    ST_INS_LINK,
    ST_REM_FIND,
    ST_REM_PRED,
    ST_REM_UNLINK,
    ST_REM_FREE,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    scan_clear;
    logic    scan_step;
    logic    set_pos;
    logic    set_prev;
    logic    ins_write;
    logic    ins_link;
    logic    rem_link;
    logic    rem_free;
    logic    set_status;
    status_t status_code;
    logic    load_result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_full;
    logic scan_last;
    logic cur_free;
    logic cur_match;
    logic cur_pred;
  } dp_status_t;

endpackage

// ----- design/allt_datapath.sv -----
`include "array_linked_list_table_top_defines.svh"

module allt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  allt_pkg::req_t      req,
  input  allt_pkg::ctrl_cmd_t cmd,
  output allt_pkg::dp_status_t stat,
  output allt_pkg::rsp_t      rsp
);

  logic [allt_pkg::KEY_W-1:0]   keys  [allt_pkg::SLOTS];
  logic [allt_pkg::PTR_W-1:0]   links [allt_pkg::SLOTS];
  logic [allt_pkg::SLOTS-1:0]   used;
  logic [allt_pkg::PTR_W-1:0]   head;
  logic [allt_pkg::PTR_W-1:0]   tail;
  logic [allt_pkg::COUNT_W-1:0] count;
  logic [allt_pkg::COUNT_W-1:0] count_dec;

  logic [allt_pkg::KEY_W-1:0]   key;
  logic [allt_pkg::SLOT_W-1:0]  idx;
  logic [allt_pkg::SLOT_W-1:0]  pos;
  logic [allt_pkg::PTR_W-1:0]   prev;
  logic [allt_pkg::PTR_W-1:0]   next;
  allt_pkg::status_t            status;

  logic [allt_pkg::PTR_W-1:0]   pos_ptr;
  logic [allt_pkg::PTR_W-1:0]   cur_link;
  logic                         tail_null;
  logic                         prev_null;

  assign pos_ptr   = {1'b0, pos};
  assign cur_link  = links[idx];
  assign tail_null = (tail >= allt_pkg::NULL_PTR);
  assign prev_null = (prev >= allt_pkg::NULL_PTR);
  assign count_dec = count - allt_pkg::COUNT_W'(1);

  // Status of the slot under the scan index
  assign stat.is_full   = (count == allt_pkg::FULL_CNT);
  assign stat.scan_last = (idx == allt_pkg::LAST_SLOT);
  assign stat.cur_free  = !used[idx];
  assign stat.cur_match = used[idx] && (keys[idx] == key);
  assign stat.cur_pred  = used[idx] && (idx != pos) && (cur_link == pos_ptr);

  // Hold the item, scan index and found slots
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key  <= req.key;
      prev <= allt_pkg::NULL_PTR;
    end
    if (cmd.scan_clear) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + allt_pkg::SLOT_W'(1);
    end
    if (cmd.set_pos) begin
      pos  <= idx;
      next <= cur_link;
    end
    if (cmd.set_prev) begin
      prev <= {1'b0, idx};
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end
  end

  // Store keys; freed keys are never compared, so leave them
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      keys[pos] <= key;
    end
  end

  // Update links, occupancy, head, tail and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < allt_pkg::SLOTS; i++) begin
        links[i] <= allt_pkg::NULL_PTR;
      end
      used  <= '0;
      head  <= allt_pkg::NULL_PTR;
      tail  <= allt_pkg::NULL_PTR;
      count <= '0;
    end else begin
      if (cmd.ins_write) begin
        links[pos] <= allt_pkg::NULL_PTR;
        used[pos]  <= 1'b1;
      end
      if (cmd.ins_link) begin
        if (count == '0 || tail_null) begin
          head <= pos_ptr;
        end else begin
          links[tail[allt_pkg::SLOT_W-1:0]] <= pos_ptr;
        end
        tail  <= pos_ptr;
        count <= count + allt_pkg::COUNT_W'(1);
      end
      if (cmd.rem_link && !prev_null) begin
        if (tail == pos_ptr) begin
          links[prev[allt_pkg::SLOT_W-1:0]] <= allt_pkg::NULL_PTR;
        end else if (head != pos_ptr) begin
          links[prev[allt_pkg::SLOT_W-1:0]] <= next;
        end
      end
      if (cmd.rem_free) begin
        links[pos] <= allt_pkg::NULL_PTR;
        used[pos]  <= 1'b0;
        count      <= count_dec;
        if (count_dec == '0) begin
          head <= allt_pkg::NULL_PTR;
          tail <= allt_pkg::NULL_PTR;
        end else begin
          if (head == pos_ptr) begin
            head <= next;
          end
          if (tail == pos_ptr) begin
            tail <= prev;
          end
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp.status      <= status;
      rsp.slot        <= (status == allt_pkg::STATUS_DONE) ? pos : '0;
      rsp.entry_count <= count;
      rsp.head_slot   <= head;
      rsp.tail_slot   <= tail;
    end
  end

  `ALLT_ASSERT_NEVER(a_count_range, clk, rst, count > allt_pkg::FULL_CNT)
  `ALLT_ASSERT(a_empty_null, clk, rst,
    (count == '0) |-> (head == allt_pkg::NULL_PTR && tail == allt_pkg::NULL_PTR))
  `ALLT_ASSERT(a_used_count, clk, rst,
    !cmd.ins_link |-> ($countones(used) == 32'(count)))

endmodule

// ----- design/allt_ctrl.sv -----
`include "array_linked_list_table_top_defines.svh"

module allt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  allt_pkg::command_t   req_command,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  allt_pkg::dp_status_t stat,
  output allt_pkg::ctrl_cmd_t  cmd
);

  allt_pkg::state_t state;
  allt_pkg::state_t state_next;
  logic             rsp_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= allt_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = allt_pkg::STATUS_DONE;
    req_ready       = 1'b0;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    unique case (state)
      allt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item  = 1'b1;
          cmd.scan_clear = 1'b1;
          if (req_command == allt_pkg::CMD_REMOVE) begin
            state_next = allt_pkg::ST_REM_FIND;
          end else if (stat.is_full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = allt_pkg::STATUS_FULL;
            state_next      = allt_pkg::ST_RESP;
          end else begin
            state_next = allt_pkg::ST_INS_SCAN;
          end
        end
      end
      allt_pkg::ST_INS_SCAN: begin
        if (stat.cur_free) begin
          cmd.set_pos = 1'b1;
          state_next  = allt_pkg::ST_INS_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      allt_pkg::ST_INS_WRITE: begin
        cmd.ins_write = 1'b1;
        state_next    = allt_pkg::ST_INS_LINK;
      end
      allt_pkg::ST_INS_LINK: begin
        cmd.ins_link   = 1'b1;
        cmd.set_status = 1'b1;
        state_next     = allt_pkg::ST_RESP;
      end
      allt_pkg::ST_REM_FIND: begin
        if (stat.cur_match) begin
          cmd.set_pos    = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = allt_pkg::ST_REM_PRED;
        end else if (stat.scan_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = allt_pkg::STATUS_MISS;
          state_next      = allt_pkg::ST_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      allt_pkg::ST_REM_PRED: begin
        if (stat.cur_pred) begin
          cmd.set_prev = 1'b1;
          state_next   = allt_pkg::ST_REM_UNLINK;
        end else if (stat.scan_last) begin
          state_next = allt_pkg::ST_REM_UNLINK;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      allt_pkg::ST_REM_UNLINK: begin
        cmd.rem_link = 1'b1;
        state_next   = allt_pkg::ST_REM_FREE;
      end
      allt_pkg::ST_REM_FREE: begin
        cmd.rem_free   = 1'b1;
        cmd.set_status = 1'b1;
        state_next     = allt_pkg::ST_RESP;
      end
      allt_pkg::ST_RESP: begin
        // Load the result once the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.load_result = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = allt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = allt_pkg::ST_IDLE;
      end
    endcase
  end

  `ALLT_ASSERT(a_load_free, clk, rst, cmd.load_result |-> (!rsp_valid || rsp_ready))
  `ALLT_ASSERT(a_one_item, clk, rst, (req_valid && req_ready) |=> !req_ready)
  `ALLT_ASSERT(a_result_after_load, clk, rst, cmd.load_result |=> rsp_valid)

endmodule

// ----- design/array_linked_list_table_top.sv -----
// Linked list of 20-bit keys kept in a 16-slot array with an occupancy map.
// Request channel (req_valid/req_ready/req): command insert appends the key
// in the lowest free slot after the tail; command remove unlinks the first
// occupied slot, in index order, holding the key.
// Response channel (rsp_valid/rsp_ready/rsp): one item per request with the
// status, the slot written or freed, and the count, head and tail after it.
// One request is worked at a time. The slot scans advance one slot per
// cycle through the shared scan index:
//   insert: scan from slot 0 to the first free slot, then write, link and
//           respond; a full table answers without a scan.
//   remove: scan from slot 0 to the first match, then scan again from slot 0
//           for its predecessor (to the last slot when the head is removed),
//           then unlink, free and respond; a missing key scans every slot.
// req_ready rises again the cycle after the response is loaded. A stalled
// response waits in the output register while the next request is taken
// and worked; only the load of that next response waits for rsp_ready.
// Synchronous reset empties the list (head and tail null, count zero).
module array_linked_list_table_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  allt_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output allt_pkg::rsp_t  rsp
);

  allt_pkg::ctrl_cmd_t  cmd;
  allt_pkg::dp_status_t stat;

  allt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_command (req.command),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  allt_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ----- test/array_linked_list_table_top_test.sv -----
module array_linked_list_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1675;
  localparam int IDLE_PCT     = 29;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    allt_pkg::req_t req;
    bit             typed;
    allt_pkg::rsp_t want;
  } stim_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  allt_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  allt_pkg::rsp_t rsp;

  // Shadow copy of the slot array and list pointers
  logic [allt_pkg::KEY_W-1:0]   list_keys  [allt_pkg::SLOTS];
  logic [allt_pkg::PTR_W-1:0]   list_links [allt_pkg::SLOTS];
  logic                         list_used  [allt_pkg::SLOTS];
  logic [allt_pkg::PTR_W-1:0]   list_head;
  logic [allt_pkg::PTR_W-1:0]   list_tail;
  logic [allt_pkg::COUNT_W-1:0] list_count;

  allt_pkg::rsp_t             expected_rsp_q[$];
  stim_row_t                  directed_rows[$];
  logic [allt_pkg::KEY_W-1:0] key_pool[8];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  array_linked_list_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Apply one command to the shadow list and return the response it yields
  function automatic allt_pkg::rsp_t apply_list_command(input allt_pkg::req_t r);
    allt_pkg::rsp_t res;
    int   pos;
    int   prev;
    int   nxt;
    pos  = allt_pkg::SLOTS;
    prev = allt_pkg::SLOTS;
    res  = '0;
    res.status = allt_pkg::STATUS_DONE;
    if (r.command == allt_pkg::CMD_INSERT) begin
      if (list_count < allt_pkg::FULL_CNT) begin
        for (int i = 0; i < allt_pkg::SLOTS; i++) begin
          if (!list_used[i]) begin
            pos = i;
            break;
          end
        end
      end
      if (pos == allt_pkg::SLOTS) begin
        res.status = allt_pkg::STATUS_FULL;
      end else begin
        list_keys[pos]  = r.key;
        list_used[pos]  = 1'b1;
        list_links[pos] = allt_pkg::NULL_PTR;
        if (list_count == 0 || list_tail >= allt_pkg::NULL_PTR) begin
          list_head = allt_pkg::PTR_W'(pos);
        end else begin
          list_links[list_tail] = allt_pkg::PTR_W'(pos);
        end
        list_tail  = allt_pkg::PTR_W'(pos);
        list_count = list_count + 1'b1;
        res.slot   = allt_pkg::SLOT_W'(pos);
      end
    end else begin
      // first occupied slot in index order holding the key
      for (int i = 0; i < allt_pkg::SLOTS; i++) begin
        if (list_used[i] && list_keys[i] == r.key) begin
          pos = i;
          break;
        end
      end
      if (pos == allt_pkg::SLOTS) begin
        res.status = allt_pkg::STATUS_MISS;
      end else begin
        for (int i = 0; i < allt_pkg::SLOTS; i++) begin
          if (list_used[i] && i != pos &&
              list_links[i] == allt_pkg::PTR_W'(pos)) begin
            prev = i;
            break;
          end
        end
        nxt = list_links[pos];
        if (list_head == allt_pkg::PTR_W'(pos)) begin
          list_head = allt_pkg::PTR_W'(nxt);
        end else if (prev != allt_pkg::SLOTS) begin
          list_links[prev] = allt_pkg::PTR_W'(nxt);
        end
        if (list_tail == allt_pkg::PTR_W'(pos)) begin
          list_tail = allt_pkg::PTR_W'(prev);
          if (prev != allt_pkg::SLOTS) list_links[prev] = allt_pkg::NULL_PTR;
        end
        list_keys[pos]  = '0;
        list_links[pos] = allt_pkg::NULL_PTR;
        list_used[pos]  = 1'b0;
        if (list_count > 0) list_count = list_count - 1'b1;
        if (list_count == 0) begin
          list_head = allt_pkg::NULL_PTR;
          list_tail = allt_pkg::NULL_PTR;
        end
        res.slot = allt_pkg::SLOT_W'(pos);
      end
    end
    res.entry_count = list_count;
    res.head_slot   = list_head;
    res.tail_slot   = list_tail;
    return res;
  endfunction

  function automatic void add_row(input allt_pkg::command_t c,
                                  input logic [allt_pkg::KEY_W-1:0] k,
                                  input bit typed = 1'b0,
                                  input allt_pkg::rsp_t want = '0);
    stim_row_t row;
    row.req.command = c;
    row.req.key     = k;
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endfunction

  // Present one item, hold it until accepted, then record its expected response
  task automatic send_item(input allt_pkg::req_t r, input bit typed,
                           input allt_pkg::rsp_t want);
    allt_pkg::rsp_t predicted;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_list_command(r);
    expected_rsp_q.push_back(typed ? want : predicted);
  endtask

  // Hold the sender until every outstanding response has come back
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Stall the response side at random and check each response item
  always @(posedge clk) begin : rsp_side
    allt_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with none pending: %p", rsp));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", rsp.slot, want.slot));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp.entry_count, want.entry_count));
          if (rsp.head_slot !== want.head_slot)
            report_mismatch($sformatf("head_slot got %0d want %0d",
                                      rsp.head_slot, want.head_slot));
          if (rsp.tail_slot !== want.tail_slot)
            report_mismatch($sformatf("tail_slot got %0d want %0d",
                                      rsp.tail_slot, want.tail_slot));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    allt_pkg::req_t r;
    bit   filling;
    int   phase_left;
    int   pick;
    filling    = 1'b1;
    phase_left = 0;

    for (int i = 0; i < allt_pkg::SLOTS; i++) begin
      list_keys[i]  = '0;
      list_links[i] = allt_pkg::NULL_PTR;
      list_used[i]  = 1'b0;
    end
    list_head  = allt_pkg::NULL_PTR;
    list_tail  = allt_pkg::NULL_PTR;
    list_count = '0;

    // small key pool so removes and duplicates hit often
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = allt_pkg::KEY_W'($urandom);

    // empty list, sole element, fill to full, then head, tail, middle and miss
    add_row(allt_pkg::CMD_REMOVE, '0, 1'b1,
            '{allt_pkg::STATUS_MISS, 4'd0, 5'd0, allt_pkg::NULL_PTR, allt_pkg::NULL_PTR});
    add_row(allt_pkg::CMD_INSERT, '0, 1'b1,
            '{allt_pkg::STATUS_DONE, 4'd0, 5'd1, 5'd0, 5'd0});
    add_row(allt_pkg::CMD_REMOVE, '0, 1'b1,
            '{allt_pkg::STATUS_DONE, 4'd0, 5'd0, allt_pkg::NULL_PTR, allt_pkg::NULL_PTR});
    add_row(allt_pkg::CMD_INSERT, '1, 1'b1,
            '{allt_pkg::STATUS_DONE, 4'd0, 5'd1, 5'd0, 5'd0});
    for (int i = 1; i < allt_pkg::SLOTS; i++)
      add_row(allt_pkg::CMD_INSERT, allt_pkg::KEY_W'((i == 9) ? 5 : i));
    add_row(allt_pkg::CMD_INSERT, 20'hABCDE, 1'b1,
            '{allt_pkg::STATUS_FULL, 4'd0, allt_pkg::FULL_CNT, 5'd0,
              allt_pkg::PTR_W'(allt_pkg::LAST_SLOT)});
    add_row(allt_pkg::CMD_REMOVE, '1);
    add_row(allt_pkg::CMD_REMOVE, allt_pkg::KEY_W'(15));
    add_row(allt_pkg::CMD_REMOVE, allt_pkg::KEY_W'(5));
    add_row(allt_pkg::CMD_REMOVE, 20'h12345);
    add_row(allt_pkg::CMD_INSERT, 20'h55555);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain_responses();

    // alternate fill-heavy and drain-heavy phases with random content
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      no_idle <= (n >= 300 && n < 700);
      if (n == 800) drain_responses();

      pick = $urandom_range(0, 99);
      if ((filling && pick < 75) || (!filling && pick < 25)) begin
        r.command = allt_pkg::CMD_INSERT;
        r.key = ($urandom_range(0, 99) < 60) ? key_pool[$urandom_range(0, 7)]
                                              : allt_pkg::KEY_W'($urandom);
      end else begin
        r.command = allt_pkg::CMD_REMOVE;
        if (list_count != 0 && $urandom_range(0, 99) < 80) begin
          // remove a key that is in the list
          pick = $urandom_range(0, allt_pkg::SLOTS - 1);
          while (!list_used[pick]) pick = (pick + 1) % allt_pkg::SLOTS;
          r.key = list_keys[pick];
        end else begin
          r.key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 7)]
                                       : allt_pkg::KEY_W'($urandom);
        end
      end
      send_item(r, 1'b0, '0);
    end

    req_valid <= 1'b0;
    no_idle   <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
